FILE: design/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Data width, register indexes, divider side-data types and the compensation formula constants.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int DATA_W = 32;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  localparam logic [31:0] K_B6_OFFSET = 32'd4000;
  localparam logic [31:0] K_P_SQ      = 32'd3038;
  localparam logic [31:0] K_P_LIN     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] K_P_OFFSET  = 32'd3791;
  localparam logic [31:0] K_B7_SCALE  = 32'd50000;
  localparam logic [31:0] K_B4_BIAS   = 32'd32768;

  // Items riding alongside the temperature divider
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        neg;
    logic        dz;
  } t_side_t;

  // Items riding alongside the pressure divider
  typedef struct packed {
    logic [31:0] temp;
    logic        dbl;
    logic        err;
  } p_side_t;

endpackage

`default_nettype wire

FILE: design/barometric_sensor_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: integer temperature / pressure compensation
// Turns raw temperature and pressure readings into 0.1 degC and pascals using
// ten calibration words and the oversampling setting.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_stall       raw_temperature, raw_pressure
//  output    out_valid / out_stall     temperature_tenths, pressure_pa,
//                                      divide_error
//  config    psel/penable/pwrite/...   32-bit registers at 4*index
//
//  One item enters per cycle while the output is not stalled; the pipeline has
//  11 arithmetic stages plus two 32-stage dividers that retire one quotient bit per stage.
//  Reset clears every valid bit; calibration resets to 0, oversampling to 1.
//  A stall on the output freezes the whole pipeline and raises in_stall in
//  the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] raw_temperature,
  input  wire logic [18:0] raw_pressure,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      temperature_tenths,
  output logic [31:0]      pressure_pa,
  output logic             divide_error,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // arithmetic shift right of a 32-bit pattern
  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    asr = $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] c_ac12, c_ac34, c_ac56, c_b12, c_mcmd;
  logic [1:0]  oss;
  logic        wr;
  logic [2:0]  widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ac12 <= '0;
      c_ac34 <= '0;
      c_ac56 <= '0;
      c_b12  <= '0;
      c_mcmd <= '0;
      oss    <= 2'd1;
    end else if (wr) begin
      unique case (widx)
        REG_AC1_AC2: c_ac12 <= pwdata;
        REG_AC3_AC4: c_ac34 <= pwdata;
        REG_AC5_AC6: c_ac56 <= pwdata;
        REG_B1_B2:   c_b12  <= pwdata;
        REG_MC_MD:   c_mcmd <= pwdata;
        REG_OSS:     oss    <= pwdata[1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_AC1_AC2: prdata = c_ac12;
      REG_AC3_AC4: prdata = c_ac34;
      REG_AC5_AC6: prdata = c_ac56;
      REG_B1_B2:   prdata = c_b12;
      REG_MC_MD:   prdata = c_mcmd;
      REG_OSS:     prdata = {30'd0, oss};
      default:     prdata = '0;
    endcase
  end

  // Calibration words, widened to 32 bits
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(c_ac12[31:16]);
  assign ac2 = sx16(c_ac12[15:0]);
  assign ac3 = sx16(c_ac34[31:16]);
  assign ac4 = {16'd0, c_ac34[15:0]};
  assign ac5 = {16'd0, c_ac56[31:16]};
  assign ac6 = {16'd0, c_ac56[15:0]};
  assign b1  = sx16(c_b12[31:16]);
  assign b2  = sx16(c_b12[15:0]);
  assign mc  = sx16(c_mcmd[31:16]);
  assign md  = sx16(c_mcmd[15:0]);

  // --------------------------------------------------------------------------
  // Global advance: every stage moves together unless the output is held
  // --------------------------------------------------------------------------
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A: (ut - ac6) * ac5
  logic        va;
  logic [31:0] a_prod;
  logic [18:0] a_up;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod <= ({16'd0, raw_temperature} - ac6) * ac5;
      a_up   <= raw_pressure;
    end
  end

  // Temperature divider: (mc << 11) / (x1 + md), signs split off
  logic [31:0] t_x1, t_den, t_num, t_uden, t_unum;
  t_side_t     t_sin, t_sout;
  logic        v1;
  logic [31:0] q1;

  always_comb begin
    t_x1   = asr(a_prod, 15);
    t_den  = t_x1 + md;
    t_num  = mc << 11;
    t_unum = t_num[31] ? (32'd0 - t_num) : t_num;
    t_uden = t_den[31] ? (32'd0 - t_den) : t_den;
    t_sin  = '{x1: t_x1, up: a_up, neg: t_num[31] ^ t_den[31], dz: (t_den == 32'd0)};
  end

  bsc_div #(.W(DATA_W), .SIDE_W($bits(t_side_t))) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (va),
    .num      (t_unum),
    .den      (t_uden),
    .side_in  (t_sin),
    .out_vld  (v1),
    .quo      (q1),
    .side_out (t_sout)
  );

  // Stage C: b5, temperature, b6
  logic        vc;
  logic [31:0] c_temp, c_b6;
  logic [18:0] c_up;
  logic        c_dz;
  logic [31:0] b5;

  assign b5 = t_sout.x1 + (t_sout.neg ? (32'd0 - q1) : q1);

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (adv) vc <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_temp <= asr(b5 + 32'd8, 4);
      c_b6   <= b5 - K_B6_OFFSET;
      c_up   <= t_sout.up;
      c_dz   <= t_sout.dz;
    end
  end

  // Stage D: b6 squared and the two linear products in b6
  logic        vd;
  logic [31:0] d_sq, d_m2, d_m3, d_temp;
  logic [18:0] d_up;
  logic        d_dz;

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (adv) vd <= vc;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_sq   <= c_b6 * c_b6;
      d_m2   <= ac2 * c_b6;
      d_m3   <= ac3 * c_b6;
      d_temp <= c_temp;
      d_up   <= c_up;
      d_dz   <= c_dz;
    end
  end

  // Stage F: products with the scaled square
  logic        vf;
  logic [31:0] f_m1, f_m2, f_x2a, f_x1c, f_temp;
  logic [18:0] f_up;
  logic        f_dz;

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (adv) vf <= vd;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_m1   <= b2 * asr(d_sq, 12);
      f_m2   <= b1 * asr(d_sq, 12);
      f_x2a  <= asr(d_m2, 11);
      f_x1c  <= asr(d_m3, 13);
      f_temp <= d_temp;
      f_up   <= d_up;
      f_dz   <= d_dz;
    end
  end

  // Stage G: b3 (signed divide by 4, toward zero) and the b4 multiplicand
  logic        vg;
  logic [31:0] g_b3, g_t, g_temp;
  logic [18:0] g_up;
  logic        g_dz;
  logic [31:0] x3, b3v, x3b;

  always_comb begin
    x3  = asr(f_m1, 11) + f_x2a;
    b3v = (((ac1 << 2) + x3) << oss) + 32'd2;
    x3b = asr(f_x1c + asr(f_m2, 16) + 32'd2, 2);
  end

  always_ff @(posedge clk) begin
    if (rst) vg <= 1'b0;
    else if (adv) vg <= vf;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      g_b3   <= asr(b3v + (b3v[31] ? 32'd3 : 32'd0), 2);
      g_t    <= x3b + K_B4_BIAS;
      g_temp <= f_temp;
      g_up   <= f_up;
      g_dz   <= f_dz;
    end
  end

  // Stage H: b4 and up - b3
  logic        vh;
  logic [31:0] h_b4, h_b7p, h_temp, h_b4p;
  logic        h_dz;

  assign h_b4p = ac4 * g_t;

  always_ff @(posedge clk) begin
    if (rst) vh <= 1'b0;
    else if (adv) vh <= vg;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      h_b4   <= h_b4p >> 15;
      h_b7p  <= {13'd0, g_up} - g_b3;
      h_temp <= g_temp;
      h_dz   <= g_dz;
    end
  end

  // Stage I: b7 and the error flag
  logic        vi;
  logic [31:0] i_b7, i_b4, i_temp;
  logic        i_err;

  always_ff @(posedge clk) begin
    if (rst) vi <= 1'b0;
    else if (adv) vi <= vh;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      i_b7   <= h_b7p * (K_B7_SCALE >> oss);
      i_b4   <= h_b4;
      i_temp <= h_temp;
      i_err  <= h_dz || (h_b4 == 32'd0);
    end
  end

  // Pressure divider: double before dividing when b7 fits, else after
  p_side_t     p_sin, p_sout;
  logic        v2;
  logic [31:0] q2, p_num;

  assign p_num = i_b7[31] ? i_b7 : (i_b7 << 1);
  assign p_sin = '{temp: i_temp, dbl: i_b7[31], err: i_err};

  bsc_div #(.W(DATA_W), .SIDE_W($bits(p_side_t))) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vi),
    .num      (p_num),
    .den      (i_b4),
    .side_in  (p_sin),
    .out_vld  (v2),
    .quo      (q2),
    .side_out (p_sout)
  );

  // Stage K: p and p >> 8
  logic        vk;
  logic [31:0] k_p, k_a, k_temp;
  logic        k_err;
  logic [31:0] pq;

  assign pq = p_sout.dbl ? (q2 << 1) : q2;

  always_ff @(posedge clk) begin
    if (rst) vk <= 1'b0;
    else if (adv) vk <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k_p    <= pq;
      k_a    <= asr(pq, 8);
      k_temp <= p_sout.temp;
      k_err  <= p_sout.err;
    end
  end

  // Stage L: square term and linear term
  logic        vl;
  logic [31:0] l_sq, l_m4, l_p, l_temp;
  logic        l_err;

  always_ff @(posedge clk) begin
    if (rst) vl <= 1'b0;
    else if (adv) vl <= vk;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      l_sq   <= k_a * k_a;
      l_m4   <= K_P_LIN * k_p;
      l_p    <= k_p;
      l_temp <= k_temp;
      l_err  <= k_err;
    end
  end

  // Stage M: scale the square term
  logic        vm;
  logic [31:0] m_m3, m_m4, m_p, m_temp;
  logic        m_err;

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= vl;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_m3   <= l_sq * K_P_SQ;
      m_m4   <= l_m4;
      m_p    <= l_p;
      m_temp <= l_temp;
      m_err  <= l_err;
    end
  end

  // Output register: final pressure sum; a zero divisor forces zeros
  logic [31:0] pres;
  assign pres = m_p + asr(asr(m_m3, 16) + asr(m_m4, 16) + K_P_OFFSET, 4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vm;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      temperature_tenths <= m_err ? 32'd0 : m_temp;
      pressure_pa        <= m_err ? 32'd0 : pres;
      divide_error       <= m_err;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> temperature_tenths == 32'd0 && pressure_pa == 32'd0)
    else $error("divide error with nonzero result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vm) && $stable(m_p) && out_valid)
    else $error("pipeline moved while output held");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !vm && !vk)
    else $error("valid bits survive reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

FILE: design/bsc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, W stages; side data rides
// along with each item.
// ----------------------------------------------------------------------------
module bsc_div import bsc_pkg::*; #(
  parameter int W      = 32,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [W-1:0]      num,
  input  wire logic [W-1:0]      den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_vld,
  output logic [W-1:0]           quo,
  output logic [SIDE_W-1:0]      side_out
);

  logic              vld  [0:W];
  logic [W-1:0]      nm   [0:W];
  logic [W-1:0]      dv   [0:W];
  logic [W-1:0]      rm   [0:W];
  logic [W-1:0]      qt   [0:W];
  logic [SIDE_W-1:0] sd   [0:W];

  assign vld[0] = in_vld;
  assign nm[0]  = num;
  assign dv[0]  = den;
  assign rm[0]  = '0;
  assign qt[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] rsh;
    logic [W:0] dif;
    logic       ge;
    assign rsh = {rm[i], nm[i][W-1]};
    assign dif = rsh - {1'b0, dv[i]};
    assign ge  = !dif[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nm[i+1] <= {nm[i][W-2:0], 1'b0};
        dv[i+1] <= dv[i];
        rm[i+1] <= ge ? dif[W-1:0] : rsh[W-1:0];
        qt[i+1] <= {qt[i][W-2:0], ge};
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_vld  = vld[W];
  assign quo      = qt[W];
  assign side_out = sd[W];

endmodule

`default_nettype wire
